// ===== src/gld_pkg.sv =====
// Package: shared constants, types and codes of the GIF LZW decoder.
`default_nettype none
package gld_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned MAX_CODE_BITS_DEF = 12;
  localparam int unsigned LZW_MIN_LOW       = 2;
  localparam int unsigned LZW_MIN_HIGH      = 11;
  localparam int unsigned LZW_MIN_RESET     = 8;
  localparam int unsigned BUF_BITS          = 32;
  localparam int unsigned BYTE_BITS         = 8;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LZW_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS = 2'd1;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_TAKEN = 3'd0,
    ST_PIXEL = 3'd1,
    ST_NEED  = 3'd2,
    ST_END   = 3'd3,
    ST_BAD   = 3'd4,
    ST_FULL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FIN_RUN = 2'd0,
    FIN_END = 2'd1,
    FIN_BAD = 2'd2
  } fin_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WALK,
    S_WAIT,
    S_FIX,
    S_ADD,
    S_POP,
    S_POPD
  } state_e;

  // classified command word handed from front to back
  typedef struct packed {
    logic                 is_pull;
    logic [BYTE_BITS-1:0] data_byte;
  } cmd_word_t;

endpackage
`default_nettype wire

// ===== src/gld_if.sv =====
// Interfaces: command, result and configuration channels.
`default_nettype none
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic [2:0] status;
  modport source (output valid, output pixel_index, output status, input ready);
  modport sink   (input valid, input pixel_index, input status, output ready);
endinterface

interface gld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/gld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;
endmodule
`default_nettype wire

// ===== src/gld_front.sv =====
// Front end: accepts command words, classifies them, queues two deep.
`default_nettype none
module gld_front import gld_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  gld_in_if.sink         in_ch_i,
  output logic           deq_valid_o,
  output cmd_word_t      deq_word_o,
  input  wire logic      deq_ready_i
);
  cmd_word_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       enq, deq;

  assign in_ch_i.ready = (cnt_q != 2'd2);
  assign enq           = in_ch_i.valid && in_ch_i.ready;
  assign deq_valid_o   = (cnt_q != 2'd0);
  assign deq           = deq_valid_o && deq_ready_i;
  assign deq_word_o    = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload slots, classified on entry
  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_ptr_q].is_pull   <= (cmd_e'(in_ch_i.cmd) == CMD_PULL);
      slot_q[wr_ptr_q].data_byte <= in_ch_i.data_byte;
    end
  end
endmodule
`default_nettype wire

// ===== src/gld_engine.sv =====
// Back end: bit buffer, code fetch, chain walk, table update, pixel pop.
`default_nettype none
module gld_engine import gld_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      deq_valid_i,
  input  cmd_word_t      deq_word_i,
  output logic           deq_ready_o,
  gld_out_if.source      out_ch_o,
  gld_cfg_if.sink        cfg_ch_i
);
  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned CODE_W = MAX_CODE_BITS;
  localparam int unsigned CW_W   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned CMP_W  = (CNT_W > CODE_W + 1) ? CNT_W : CODE_W + 1;
  localparam logic [CMP_W-1:0] TE_X  = CMP_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] TE_C  = CNT_W'(TABLE_ENTRIES);
  localparam logic [CW_W-1:0]  CW_MAX = CW_W'(MAX_CODE_BITS);

  state_e               state_q, state_d;
  logic [3:0]           mcs_q;
  logic [31:0]          max_pix_q;
  logic [BUF_BITS-1:0]  buf_q;
  logic [5:0]           bcnt_q;
  logic [CNT_W-1:0]     nfc_q;
  logic [CW_W-1:0]      cw_q;
  logic [CODE_W-1:0]    prev_q;
  logic                 pv_q;
  logic [31:0]          pix_q;
  fin_e                 fin_q;
  logic [CNT_W-1:0]     sc_q;
  logic [CODE_W-1:0]    c_q;
  logic [CODE_W-1:0]    cur_q;
  logic                 kwk_q;
  logic [7:0]           first_q;
  logic                 out_valid_q;
  logic [7:0]           out_pix_q;
  status_e              out_st_q;

  // restart values follow the size being written, if any
  logic                 cfg_wr, cfg_hit;
  logic [3:0]           mcs_sel;
  logic                 sel_ok, size_ok;
  logic [CODE_W-1:0]    clr, clr_sel;
  logic [CNT_W-1:0]     rs_nfc;
  logic [CW_W-1:0]      rs_cw;

  assign cfg_ch_i.ready = 1'b1;
  assign cfg_wr  = cfg_ch_i.valid;
  assign cfg_hit = cfg_wr && (cfg_ch_i.index == CFG_LZW_MIN ||
                              cfg_ch_i.index == CFG_MAX_PIXELS);
  assign mcs_sel = (cfg_wr && cfg_ch_i.index == CFG_LZW_MIN) ? cfg_ch_i.data[3:0]
                                                            : mcs_q;
  assign sel_ok  = (mcs_sel >= 4'(LZW_MIN_LOW)) && (mcs_sel <= 4'(LZW_MIN_HIGH));
  assign size_ok = (mcs_q >= 4'(LZW_MIN_LOW)) && (mcs_q <= 4'(LZW_MIN_HIGH));
  assign clr     = size_ok ? (CODE_W'(1) << mcs_q) : CODE_W'(4);
  assign clr_sel = sel_ok ? (CODE_W'(1) << mcs_sel) : CODE_W'(4);
  assign rs_nfc  = CNT_W'(clr_sel) + CNT_W'(2);
  assign rs_cw   = sel_ok ? (CW_W'(mcs_sel) + CW_W'(1)) : CW_W'(LZW_MIN_LOW + 1);

  // code extraction from the bit buffer
  logic [BUF_BITS-1:0]  code_mask, code_raw;
  logic [CODE_W-1:0]    code;
  logic                 need;
  logic [CMP_W-1:0]     code_x, nfc_x, c_x;
  logic                 is_clr, is_eoi, is_known, is_kwk;

  assign code_mask = (BUF_BITS'(1) << cw_q) - BUF_BITS'(1);
  assign code_raw  = buf_q & code_mask;
  assign code      = code_raw[CODE_W-1:0];
  assign need      = bcnt_q < 6'(cw_q);
  assign code_x    = CMP_W'(code);
  assign nfc_x     = CMP_W'(nfc_q);
  assign c_x       = CMP_W'(c_q);
  assign is_clr    = (code == clr);
  assign is_eoi    = (code == clr + CODE_W'(1));
  assign is_known  = code_x < nfc_x;
  assign is_kwk    = (code_x == nfc_x) && pv_q;

  // chain walk and table update conditions
  logic                 is_node, node_bad, root_bad, add_ok, widen;
  logic [CNT_W-1:0]     nfc_next;

  assign is_node  = c_q >= clr;
  assign node_bad = (sc_q >= TE_C) || (c_x >= TE_X);
  assign root_bad = sc_q >= TE_C;
  assign add_ok   = pv_q && (nfc_q < TE_C);
  assign nfc_next = nfc_q + CNT_W'(1);
  assign widen    = (cw_q < CW_MAX) && (CMP_W'(nfc_next) == (CMP_W'(1) << cw_q));

  // front command checks; a result taken this cycle frees the output register
  logic go, is_pull, buf_full, pull_bad, pull_end;
  assign go       = (state_q == S_IDLE) && deq_valid_i && (!out_valid_q || out_ch_o.ready);
  assign is_pull  = deq_word_i.is_pull;
  assign buf_full = bcnt_q > 6'(BUF_BITS - BYTE_BITS);
  assign pull_bad = !size_ok || fin_q == FIN_BAD;
  assign pull_end = fin_q == FIN_END || pix_q >= max_pix_q;

  // memories
  logic [CODE_W-1:0] pre_rd;
  logic [7:0]        suf_rd, stk_rd;
  logic              tab_we, stk_we;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata;

  gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk_i, .we_i(tab_we), .waddr_i(nfc_q[IDX_W-1:0]), .wdata_i(prev_q),
    .raddr_i(c_q[IDX_W-1:0]), .rdata_o(pre_rd)
  );
  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk_i, .we_i(tab_we), .waddr_i(nfc_q[IDX_W-1:0]), .wdata_i(first_q),
    .raddr_i(c_q[IDX_W-1:0]), .rdata_o(suf_rd)
  );
  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go && is_pull && !pull_bad && !pull_end) begin
          state_d = (sc_q != '0) ? S_POP : S_FETCH;
        end
      end
      S_FETCH: begin
        if (need || is_eoi) begin
          state_d = S_IDLE;
        end else if (is_clr) begin
          state_d = S_FETCH;
        end else if (is_known || is_kwk) begin
          state_d = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (is_node) begin
          state_d = node_bad ? S_IDLE : S_WAIT;
        end else if (root_bad) begin
          state_d = S_IDLE;
        end else begin
          state_d = kwk_q ? S_FIX : S_ADD;
        end
      end
      S_WAIT:  state_d = S_WALK;
      S_FIX:   state_d = S_ADD;
      S_ADD:   state_d = S_POP;
      S_POP:   state_d = S_POPD;
      S_POPD:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: result and memory controls
  logic    emit;
  status_e emit_st;
  always_comb begin
    emit      = 1'b0;
    emit_st   = ST_TAKEN;
    tab_we    = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = sc_q[IDX_W-1:0];
    stk_wdata = suf_rd;
    stk_raddr = sc_q[IDX_W-1:0] - IDX_W'(1);
    case (state_q)
      S_IDLE: begin
        if (go) begin
          if (!is_pull) begin
            emit    = 1'b1;
            emit_st = buf_full ? ST_FULL : ST_TAKEN;
          end else if (pull_bad) begin
            emit    = 1'b1;
            emit_st = ST_BAD;
          end else if (pull_end) begin
            emit    = 1'b1;
            emit_st = ST_END;
          end
        end
      end
      S_FETCH: begin
        if (need) begin
          emit    = 1'b1;
          emit_st = ST_NEED;
        end else if (!is_clr && is_eoi) begin
          emit    = 1'b1;
          emit_st = ST_END;
        end else if (!is_clr && !is_known && !is_kwk) begin
          emit    = 1'b1;
          emit_st = ST_BAD;
        end
      end
      S_WALK: begin
        if ((is_node && node_bad) || (!is_node && root_bad)) begin
          emit    = 1'b1;
          emit_st = ST_BAD;
        end else if (!is_node) begin
          stk_we    = 1'b1;
          stk_wdata = c_q[7:0];
        end
      end
      S_WAIT: stk_we = 1'b1;
      S_FIX: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = first_q;
      end
      S_ADD: tab_we = add_ok;
      S_POPD: begin
        emit    = 1'b1;
        emit_st = ST_PIXEL;
      end
      default: ;
    endcase
  end

  assign deq_ready_o = emit;

  // state register and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mcs_q      <= 4'(LZW_MIN_RESET);
      max_pix_q  <= '0;
      buf_q      <= '0;
      bcnt_q     <= '0;
      nfc_q      <= CNT_W'((1 << LZW_MIN_RESET) + 2);
      cw_q       <= CW_W'(LZW_MIN_RESET + 1);
      prev_q     <= '0;
      pv_q       <= 1'b0;
      pix_q      <= '0;
      fin_q      <= FIN_RUN;
      sc_q       <= '0;
      c_q        <= '0;
      cur_q      <= '0;
      kwk_q      <= 1'b0;
      first_q    <= '0;
    end else if (cfg_hit) begin
      // a register write restarts decoding
      if (cfg_ch_i.index == CFG_LZW_MIN) begin
        mcs_q <= cfg_ch_i.data[3:0];
      end else begin
        max_pix_q <= cfg_ch_i.data;
      end
      state_q <= S_IDLE;
      buf_q   <= '0;
      bcnt_q  <= '0;
      nfc_q   <= rs_nfc;
      cw_q    <= rs_cw;
      prev_q  <= '0;
      pv_q    <= 1'b0;
      pix_q   <= '0;
      fin_q   <= FIN_RUN;
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (go) begin
            if (!is_pull) begin
              if (!buf_full) begin
                buf_q  <= buf_q | (BUF_BITS'(deq_word_i.data_byte) << bcnt_q);
                bcnt_q <= bcnt_q + 6'(BYTE_BITS);
              end
            end else if (!pull_bad && pull_end) begin
              fin_q <= FIN_END;
              sc_q  <= '0;
            end
          end
        end
        S_FETCH: begin
          if (!need) begin
            buf_q  <= buf_q >> cw_q;
            bcnt_q <= bcnt_q - 6'(cw_q);
            cur_q  <= code;
            if (is_clr) begin
              nfc_q  <= rs_nfc;
              cw_q   <= rs_cw;
              prev_q <= '0;
              pv_q   <= 1'b0;
              sc_q   <= '0;
            end else if (is_eoi) begin
              fin_q <= FIN_END;
            end else if (is_known) begin
              c_q   <= code;
              sc_q  <= '0;
              kwk_q <= 1'b0;
            end else if (is_kwk) begin
              c_q   <= prev_q;
              sc_q  <= CNT_W'(1);
              kwk_q <= 1'b1;
            end else begin
              fin_q <= FIN_BAD;
              sc_q  <= '0;
            end
          end
        end
        S_WALK: begin
          if ((is_node && node_bad) || (!is_node && root_bad)) begin
            fin_q <= FIN_BAD;
            sc_q  <= '0;
          end else if (!is_node) begin
            sc_q    <= sc_q + CNT_W'(1);
            first_q <= c_q[7:0];
          end
        end
        S_WAIT: begin
          sc_q <= sc_q + CNT_W'(1);
          c_q  <= pre_rd;
        end
        S_ADD: begin
          if (add_ok) begin
            nfc_q <= nfc_next;
            if (widen) begin
              cw_q <= cw_q + CW_W'(1);
            end
          end
          prev_q <= cur_q;
          pv_q   <= 1'b1;
        end
        S_POP: begin
          sc_q  <= sc_q - CNT_W'(1);
          pix_q <= pix_q + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_st_q    <= ST_TAKEN;
    end else if (emit) begin
      out_valid_q <= 1'b1;
      out_st_q    <= emit_st;
      out_pix_q   <= (emit_st == ST_PIXEL) ? stk_rd : 8'd0;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.pixel_index = out_pix_q;
  assign out_ch_o.status      = out_st_q;
endmodule
`default_nettype wire

// ===== src/gif_lzw_decoder_core.sv =====
// Top level of the GIF LZW decoder: command queue front, decode engine back.
//
// Channel   Dir  Payload                    Word
// in_ch_i   in   cmd[0], data_byte[7:0]     push byte or pull pixel
// out_ch_o  out  pixel_index[7:0], status   one result per command
// cfg_ch_i  in   index[1:0], data[31:0]     0 min code size, 1 max pixels
//
// A push is taken by the engine in its idle state; a pull from a loaded stack
// passes start, stack RAM read and result. A pull that opens a new code passes
// a start, a fetch per code, a walk and a wait per link of its prefix chain
// (table RAM read), the root, a fix for a KwKwK code, the table write, then the
// pop and its result. A stalled result holds the engine; one taken in the cycle
// it waits lets the next word start. Reset and a config write to index 0 or 1
// restart decoding; the tables need no clearing. The front queues two words.
`default_nettype none
module gif_lzw_decoder_core import gld_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gld_in_if.sink    in_ch_i,
  gld_out_if.source out_ch_o,
  gld_cfg_if.sink   cfg_ch_i
);
  logic      deq_valid;
  logic      deq_ready;
  cmd_word_t deq_word;

  gld_front u_front (
    .clk_i,
    .rst_ni,
    .in_ch_i,
    .deq_valid_o(deq_valid),
    .deq_word_o (deq_word),
    .deq_ready_i(deq_ready)
  );

  gld_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .deq_valid_i(deq_valid),
    .deq_word_i (deq_word),
    .deq_ready_o(deq_ready),
    .out_ch_o,
    .cfg_ch_i
  );
endmodule
`default_nettype wire

// ===== src/gld_checker.sv =====
// Checker: port-level assertions on the decoder, bound to the top level.
`default_nettype none
module gld_checker import gld_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_pix_i,
  input wire logic [2:0] out_st_i,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_i
);
  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_st_i) && $stable(out_pix_i))
    else $error("result changed while stalled");

  // status code stays in range
  a_st_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_st_i <= ST_FULL)
    else $error("status out of range");

  // only pixel results carry a nonzero index
  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_st_i != ST_PIXEL |-> out_pix_i == 8'd0)
    else $error("index on non-pixel result");

  // config writes never stall
  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write stalled");
endmodule

bind gif_lzw_decoder_core gld_checker u_gld_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_ch_o.valid),
  .out_ready_i(out_ch_o.ready),
  .out_pix_i  (out_ch_o.pixel_index),
  .out_st_i   (out_ch_o.status),
  .cfg_valid_i(cfg_ch_i.valid),
  .cfg_ready_i(cfg_ch_i.ready)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench of the GIF LZW decoder core: encoded streams in, decoded words checked.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import gld_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_ITEMS  = 1050;

  logic clk_i;
  logic rst_ni;

  gld_in_if  in_ch();
  gld_out_if out_ch();
  gld_cfg_if cfg_ch();

  gif_lzw_decoder_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  // clock, 4 ns period
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  typedef struct packed {
    logic [7:0] pix;
    status_e    st;
  } pixel_word_t;

  pixel_word_t pixel_word_q[$];
  int          err_cnt;
  int          cycle_cnt;
  bit          in_took;
  bit          cfg_took;
  bit          use_gaps;

  // decoder mirror
  logic [3:0]  dec_min;
  logic [31:0] dec_max;
  logic [11:0] dec_prefix [4096];
  logic [7:0]  dec_suffix [4096];
  logic [7:0]  dec_stack  [4097];
  int unsigned dec_depth;
  logic [31:0] dec_bits;
  int unsigned dec_nbits;
  int unsigned dec_next;
  int unsigned dec_width;
  int unsigned dec_prev;
  bit          dec_prev_ok;
  logic [31:0] dec_emitted;
  fin_e        dec_fin;

  function automatic bit dec_size_ok();
    return dec_min >= LZW_MIN_LOW && dec_min <= LZW_MIN_HIGH;
  endfunction

  function automatic int unsigned dec_clear();
    return dec_size_ok() ? (1 << dec_min) : 4;
  endfunction

  task automatic dec_table_restart();
    dec_next    = dec_clear() + 2;
    dec_width   = (dec_size_ok() ? dec_min : LZW_MIN_LOW) + 1;
    dec_prev_ok = 1'b0;
    dec_prev    = 0;
    dec_depth   = 0;
  endtask

  task automatic dec_restart();
    dec_table_restart();
    dec_bits    = '0;
    dec_nbits   = 0;
    dec_emitted = '0;
    dec_fin     = FIN_RUN;
  endtask

  // push the string of a code onto the stack; first pixel or -1 on overrun
  task automatic dec_walk(input int unsigned code, input int unsigned start,
                          output int first);
    int unsigned c;
    c = code;
    dec_depth = start;
    first = -1;
    while (c >= dec_clear()) begin
      if (dec_depth >= 4096 || c >= 4096) return;
      dec_stack[dec_depth] = dec_suffix[c];
      dec_depth++;
      c = dec_prefix[c];
    end
    if (dec_depth >= 4096) return;
    dec_stack[dec_depth] = c[7:0];
    dec_depth++;
    first = c & 8'hFF;
  endtask

  task automatic dec_step(input cmd_e cmd, input logic [7:0] data_byte,
                          output pixel_word_t res);
    int unsigned code;
    int          first;
    res = '{pix: 8'd0, st: ST_TAKEN};
    if (cmd == CMD_PUSH) begin
      if (dec_nbits + 8 > 32) begin
        res.st = ST_FULL;
        return;
      end
      dec_bits  = dec_bits | (32'(data_byte) << dec_nbits);
      dec_nbits += 8;
      return;
    end
    if (!dec_size_ok() || dec_fin == FIN_BAD) begin
      res.st = ST_BAD;
      return;
    end
    if (dec_fin == FIN_END || dec_emitted >= dec_max) begin
      dec_fin   = FIN_END;
      dec_depth = 0;
      res.st    = ST_END;
      return;
    end
    while (dec_depth == 0) begin
      if (dec_nbits < dec_width) begin
        res.st = ST_NEED;
        return;
      end
      code = dec_bits & ((32'd1 << dec_width) - 1);
      dec_bits  = dec_bits >> dec_width;
      dec_nbits -= dec_width;
      if (code == dec_clear()) begin
        dec_table_restart();
        continue;
      end
      if (code == dec_clear() + 1) begin
        dec_fin = FIN_END;
        res.st  = ST_END;
        return;
      end
      first = -1;
      if (code < dec_next) begin
        dec_walk(code, 0, first);
      end else if (code == dec_next && dec_prev_ok) begin
        // KwKwK: string of previous code plus its own first pixel
        dec_walk(dec_prev, 1, first);
        if (first >= 0) dec_stack[0] = first[7:0];
      end
      if (first < 0) begin
        dec_fin   = FIN_BAD;
        dec_depth = 0;
        res.st    = ST_BAD;
        return;
      end
      if (dec_prev_ok && dec_next < 4096) begin
        dec_prefix[dec_next] = dec_prev[11:0];
        dec_suffix[dec_next] = first[7:0];
        dec_next++;
        if (dec_width < 12 && dec_next == (1 << dec_width)) dec_width++;
      end
      dec_prev    = code;
      dec_prev_ok = 1'b1;
    end
    dec_depth--;
    dec_emitted++;
    res.pix = dec_stack[dec_depth];
    res.st  = ST_PIXEL;
  endtask

  // monitor: check results, then predict newly accepted words
  always @(posedge clk_i) begin
    pixel_word_t want;
    pixel_word_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pix = out_ch.pixel_index;
        got.st  = status_e'(out_ch.status);
        if (pixel_word_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word pixel %0d status %0d", $time, got.pix, got.st);
        end else begin
          want = pixel_word_q.pop_front();
          if (got.st !== want.st) begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          end
          if (got.pix !== want.pix) begin
            err_cnt++;
            $display("%0t: pixel expected %0d actual %0d", $time, want.pix, got.pix);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        dec_step(cmd_e'(in_ch.cmd), in_ch.data_byte, want);
        pixel_word_q.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_LZW_MIN) begin
          dec_min = cfg_ch.data[3:0];
          dec_restart();
        end else if (cfg_ch.index == CFG_MAX_PIXELS) begin
          dec_max = cfg_ch.data;
          dec_restart();
        end
      end
    end
    in_took  <= rst_ni && in_ch.valid && in_ch.ready;
    cfg_took <= rst_ni && cfg_ch.valid && cfg_ch.ready;
  end

  // result side stalls
  always @(negedge clk_i) begin
    out_ch.ready <= use_gaps ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input cmd_e cmd, input logic [7:0] data_byte);
    while (use_gaps && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.data_byte <= data_byte;
    do @(negedge clk_i); while (!in_took);
  endtask

  // registers change only with the engine drained
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (pixel_word_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(negedge clk_i); while (!cfg_took);
    cfg_ch.valid <= 1'b0;
  endtask

  // compressed stream for the current phase, LSB first
  logic [7:0] comp_q[$];

  task automatic build_stream(input int unsigned root_bits, input int ncodes);
    int unsigned clr;
    int unsigned nxt;
    int unsigned wid;
    int unsigned code;
    int unsigned r;
    bit          prev_ok;
    logic [63:0] acc;
    int unsigned nacc;
    clr = 1 << root_bits;
    acc = '0;
    nacc = 0;
    comp_q.delete();
    for (int i = -1; i <= ncodes; i++) begin
      r = $urandom_range(99);
      if (i < 0 || (i < ncodes && r < 3)) begin
        code    = clr;
      end else if (i == ncodes) begin
        code = clr + 1;
      end else if (prev_ok && r < 20 && nxt < 4096) begin
        code = nxt;
      end else if (prev_ok && r < 60 && nxt > clr + 2) begin
        code = $urandom_range(nxt - 1, clr + 2);
      end else begin
        code = $urandom_range(clr - 1, 0);
      end
      if (i < 0 || i == ncodes) wid = (i < 0) ? root_bits + 1 : wid;
      acc  = acc | (64'(code) << nacc);
      nacc += wid;
      if (code == clr) begin
        nxt = clr + 2;
        wid = root_bits + 1;
        prev_ok = 1'b0;
      end else begin
        if (prev_ok && nxt < 4096) begin
          nxt++;
          if (wid < 12 && nxt == (1 << wid)) wid++;
        end
        prev_ok = 1'b1;
      end
      while (nacc >= 8) begin
        comp_q.push_back(acc[7:0]);
        acc  = acc >> 8;
        nacc -= 8;
      end
    end
    if (nacc > 0) comp_q.push_back(acc[7:0]);
  endtask

  typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [31:0] value;
    cmd_e        cmd;
    logic [7:0]  data_byte;
    bit          known;
    logic [7:0]  pix;
    status_e     st;
  } stim_row_t;

  // directed rows; known marks a result read straight off the contract
  stim_row_t stim_rows[] = '{
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_END},       // max pixels 0 after reset
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'h00, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'hFF, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'hAA, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'h55, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'h01, 1, 0, ST_FULL},      // buffer full
    '{ROW_CFG, CFG_LZW_MIN, 2, CMD_PUSH, 0, 0, 0, ST_TAKEN},
    '{ROW_CFG, CFG_MAX_PIXELS, 5, CMD_PUSH, 0, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_NEED},      // empty buffer
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'h8C, 1, 0, ST_TAKEN},     // clear, 1, part of next
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 1, ST_PIXEL},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_NEED},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'h05, 1, 0, ST_TAKEN},     // KwKwK, then 2, then 0
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_END},       // pixel limit
    '{ROW_CFG, CFG_LZW_MIN, 15, CMD_PUSH, 0, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_BAD},       // bad min size
    '{ROW_CFG, CFG_LZW_MIN, 11, CMD_PUSH, 0, 0, 0, ST_TAKEN},
    '{ROW_CFG, CFG_MAX_PIXELS, 32'hFFFF_FFFF, CMD_PUSH, 0, 0, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'hFF, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PUSH, 8'hFF, 1, 0, ST_TAKEN},
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_BAD},       // code above next free
    '{ROW_WORD, 0, 0, CMD_PULL, 8'h00, 1, 0, ST_BAD}
  };

  int unsigned phase_min[]  = '{8, 2, 11, 3, 0, 5, 9, 4, 12, 6, 10, 2, 7, 11};
  logic [31:0] phase_max[]  = '{32'hFFFF_FFFF, 300, 32'hFFFF_FFFF, 1, 50, 0,
                                32'hFFFF_FFFF, 40, 20, 32'hFFFF_FFFF, 200,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

  initial begin
    int          budget;
    int          sent;
    int          quiet_start;
    bit          noise;
    cmd_e        cmd;
    logic [7:0]  data_byte;
    err_cnt         = 0;
    cycle_cnt       = 0;
    use_gaps        = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_PUSH;
    in_ch.data_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_LZW_MIN;
    cfg_ch.data     = '0;
    dec_min         = LZW_MIN_RESET;
    dec_max         = '0;
    dec_restart();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_reg(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        send_word(stim_rows[i].cmd, stim_rows[i].data_byte);
        if (stim_rows[i].known &&
            (pixel_word_q[$].st != stim_rows[i].st || pixel_word_q[$].pix != stim_rows[i].pix)) begin
          err_cnt++;
          $display("%0t: row %0d expected pixel %0d status %0d, predicted %0d/%0d", $time, i,
                   stim_rows[i].pix, stim_rows[i].st, pixel_word_q[$].pix, pixel_word_q[$].st);
        end
      end
    end

    // random phases: mostly well-formed streams, some noise
    sent = 0;
    quiet_start = RAND_ITEMS / 3;
    foreach (phase_min[p]) begin
      write_reg(CFG_LZW_MIN, phase_min[p]);
      write_reg(CFG_MAX_PIXELS, phase_max[p]);
      noise = ($urandom_range(99) < 15);
      if (phase_min[p] >= LZW_MIN_LOW && phase_min[p] <= LZW_MIN_HIGH)
        build_stream(phase_min[p], $urandom_range(40, 10));
      else
        build_stream(LZW_MIN_LOW, 10);
      budget = RAND_ITEMS / phase_min.size();
      for (int k = 0; k < budget; k++) begin
        use_gaps = !(sent >= quiet_start && sent < quiet_start + 150);
        if (noise || $urandom_range(99) < 4) begin
          cmd       = cmd_e'($urandom_range(1));
          data_byte = $urandom;
        end else if (comp_q.size() != 0 && dec_nbits + 8 <= 32 &&
                     (dec_nbits < dec_width || $urandom_range(99) < 30)) begin
          cmd       = CMD_PUSH;
          data_byte = comp_q.pop_front();
        end else begin
          cmd       = CMD_PULL;
          data_byte = $urandom;
        end
        send_word(cmd, data_byte);
        sent++;
      end
    end

    // drain
    in_ch.valid <= 1'b0;
    while (pixel_word_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
